### design/blsu_pkg.sv
`default_nettype none

package blsu_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int CLIP_BITS      = 12;
	localparam int BPP_BITS       = 7;
	localparam int STRIDE_BITS    = 16;
	localparam int ADDR_BITS      = 28;
	localparam int BYTE_BITS      = 8;
	localparam int BYTE_SHIFT     = $clog2(BYTE_BITS);
	localparam int REG_IDX_BITS   = 3;
	localparam int WR_DATA_BITS   = 16;

	localparam logic [CLIP_BITS-1:0]   CLIP_LEFT_RST   = CLIP_BITS'(0);
	localparam logic [CLIP_BITS-1:0]   CLIP_RIGHT_RST  = CLIP_BITS'(1920);
	localparam logic [CLIP_BITS-1:0]   CLIP_HEIGHT_RST = CLIP_BITS'(1080);
	localparam logic [BPP_BITS-1:0]    BPP_RST         = BPP_BITS'(32);
	localparam logic [STRIDE_BITS-1:0] ROW_STRIDE_RST  = STRIDE_BITS'(7680);

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} blsu_cmd_t;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_CLIP_LEFT   = 3'd0,
		REG_CLIP_RIGHT  = 3'd1,
		REG_CLIP_HEIGHT = 3'd2,
		REG_BPP         = 3'd3,
		REG_ROW_STRIDE  = 3'd4
	} blsu_reg_idx_t;

	typedef struct packed {
		logic [CLIP_BITS-1:0]   clip_left;
		logic [CLIP_BITS-1:0]   clip_right;
		logic [CLIP_BITS-1:0]   clip_height;
		logic [BPP_BITS-1:0]    bpp;
		logic [STRIDE_BITS-1:0] row_stride;
	} blsu_cfg_t;

endpackage

`default_nettype wire

### design/blsu_ifs.sv
`default_nettype none

interface blsu_req_if #(
	parameter int COORD_BITS = blsu_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic                         cmd;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;

	modport source (output valid, cmd, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, output ready);
endinterface

interface blsu_rsp_if #(
	parameter int COORD_BITS = blsu_pkg::COORD_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic signed [COORD_BITS-1:0]      pixel_x;
	logic signed [COORD_BITS-1:0]      pixel_y;
	logic [blsu_pkg::ADDR_BITS-1:0]    pixel_address;
	logic                              visible;
	logic                              last;

	modport source (output valid, pixel_x, pixel_y, pixel_address, visible, last, input ready);
	modport sink   (input valid, pixel_x, pixel_y, pixel_address, visible, last, output ready);
endinterface

`default_nettype wire

### design/blsu_pix_addr.sv
`default_nettype none

module blsu_pix_addr #(
	parameter int COORD_BITS = blsu_pkg::COORD_BITS_DEF
) (
	input  logic                              live,
	input  logic signed [COORD_BITS-1:0]      px,
	input  logic signed [COORD_BITS-1:0]      py,
	input  blsu_pkg::blsu_cfg_t               cfg,
	output logic                              visible,
	output logic [blsu_pkg::ADDR_BITS-1:0]    address
);
	import blsu_pkg::*;

	localparam int XW = COORD_BITS + 1;

	logic signed [XW-1:0]                  x_e;
	logic signed [XW-1:0]                  y_e;
	logic signed [XW-1:0]                  left_e;
	logic signed [XW-1:0]                  right_e;
	logic signed [XW-1:0]                  height_e;
	logic                                  in_win;
	logic [CLIP_BITS+BPP_BITS-1:0]         x_prod;
	logic [CLIP_BITS+BPP_BITS-1:0]         x_bytes;
	logic [CLIP_BITS+STRIDE_BITS-1:0]      y_prod;
	logic [ADDR_BITS-1:0]                  sum;

	assign x_e      = XW'(px);
	assign y_e      = XW'(py);
	assign left_e   = $signed(XW'(cfg.clip_left));
	assign right_e  = $signed(XW'(cfg.clip_right));
	assign height_e = $signed(XW'(cfg.clip_height));

	assign in_win = (x_e > left_e) && (x_e < right_e) &&
		!y_e[XW-1] && (y_e != '0) && (y_e < height_e);

	// inside the window both coordinates fit the clip width
	assign x_prod  = px[CLIP_BITS-1:0] * cfg.bpp;
	assign x_bytes = x_prod >> BYTE_SHIFT;
	assign y_prod  = py[CLIP_BITS-1:0] * cfg.row_stride;
	assign sum     = ADDR_BITS'(x_bytes) + ADDR_BITS'(y_prod);

	assign visible = live && in_win;
	assign address = visible ? sum : '0;

endmodule

`default_nettype wire

### design/bresenham_line_stepper_unit.sv
// Bresenham line stepper.
// Channel req carries requests: cmd START loads start and end points and
// produces no result; cmd STEP produces exactly one result on rsp.
// Each STEP result carries the current point, a clip-window visible flag,
// its framebuffer byte address (zero when not visible) and a last flag,
// then the point moves one step toward the end point. The end point is
// never drawn: the STEP that reaches it, and any STEP with no line
// loaded, returns last set and visible clear.
// A STEP result is registered and shows on rsp in the cycle after the
// STEP is accepted. Throughput: one request per cycle while rsp does not
// stall, set by the error-term update that feeds the next step.
// A result register sits between the two sides: req.ready is high while
// that register is empty or being taken in the same cycle, so a stalled
// receiver holds the result and back-pressures req after one STEP.
// Reset clears the line state (no line loaded) and loads the default clip
// window 0..1920 x 0..1080, 32 bits per pixel and a 7680-byte row stride.
// Configuration writes on wr_en/wr_index/wr_data are for idle periods.
`default_nettype none

module bresenham_line_stepper_unit #(
	parameter int COORD_BITS = blsu_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [blsu_pkg::REG_IDX_BITS-1:0]    wr_index,
	input  logic [blsu_pkg::WR_DATA_BITS-1:0]    wr_data,
	blsu_req_if.sink                             req,
	blsu_rsp_if.source                           rsp
);
	import blsu_pkg::*;

	localparam int CW  = COORD_BITS;
	localparam int DW  = COORD_BITS + 1;
	localparam int EW  = COORD_BITS + 3;
	localparam int E2W = COORD_BITS + 4;

	blsu_cfg_t cfg_q;

	logic signed [CW-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic [DW-1:0]        dx_q, dy_q;
	logic                 sxn_q, syn_q;
	logic signed [EW-1:0] err_q;
	logic                 active_q;

	logic                 out_valid_q;
	logic signed [CW-1:0] out_x_q, out_y_q;
	logic [ADDR_BITS-1:0] out_addr_q;
	logic                 out_vis_q, out_last_q;

	logic                  fire, is_step, at_end, live;
	logic signed [CW-1:0]  ax, ay, bx, by;
	logic signed [DW-1:0]  diff_x, diff_y;
	logic                  x_fwd, y_fwd;
	logic [DW-1:0]         new_dx, new_dy;
	logic signed [EW-1:0]  new_err;
	logic signed [E2W-1:0] e2, dx_s, dy_s, err_sum;
	logic                  move_x, move_y;
	logic signed [CW-1:0]  nxt_x, nxt_y;
	logic                  pix_vis;
	logic [ADDR_BITS-1:0]  pix_addr;

	assign req.ready = !out_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign is_step   = (req.cmd == CMD_STEP);
	assign at_end    = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
	assign live      = active_q && !at_end;

	assign ax = req.start_x;
	assign ay = req.start_y;
	assign bx = req.end_x;
	assign by = req.end_y;

	always_comb begin
		diff_x  = DW'(bx) - DW'(ax);
		diff_y  = DW'(by) - DW'(ay);
		x_fwd   = (ax < bx);
		y_fwd   = (ay < by);
		new_dx  = x_fwd ? unsigned'(diff_x) : unsigned'(-diff_x);
		new_dy  = y_fwd ? unsigned'(diff_y) : unsigned'(-diff_y);
		new_err = $signed({2'b00, new_dx}) - $signed({2'b00, new_dy});
	end

	always_comb begin
		e2      = $signed({err_q, 1'b0});
		dx_s    = $signed({3'b000, dx_q});
		dy_s    = $signed({3'b000, dy_q});
		move_x  = (e2 > -dy_s);
		move_y  = (e2 < dx_s);
		err_sum = E2W'(err_q);
		if (move_x) begin
			err_sum = err_sum - dy_s;
		end
		if (move_y) begin
			err_sum = err_sum + dx_s;
		end
		nxt_x = cur_x_q;
		nxt_y = cur_y_q;
		if (move_x) begin
			nxt_x = sxn_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
		end
		if (move_y) begin
			nxt_y = syn_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
		end
	end

	blsu_pix_addr #(
		.COORD_BITS(COORD_BITS)
	) u_pix_addr (
		.live    (live),
		.px      (cur_x_q),
		.py      (cur_y_q),
		.cfg     (cfg_q),
		.visible (pix_vis),
		.address (pix_addr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clip_left   <= CLIP_LEFT_RST;
			cfg_q.clip_right  <= CLIP_RIGHT_RST;
			cfg_q.clip_height <= CLIP_HEIGHT_RST;
			cfg_q.bpp         <= BPP_RST;
			cfg_q.row_stride  <= ROW_STRIDE_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_CLIP_LEFT:   cfg_q.clip_left   <= wr_data[CLIP_BITS-1:0];
				REG_CLIP_RIGHT:  cfg_q.clip_right  <= wr_data[CLIP_BITS-1:0];
				REG_CLIP_HEIGHT: cfg_q.clip_height <= wr_data[CLIP_BITS-1:0];
				REG_BPP:         cfg_q.bpp         <= wr_data[BPP_BITS-1:0];
				REG_ROW_STRIDE:  cfg_q.row_stride  <= wr_data[STRIDE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			tgt_x_q  <= '0;
			tgt_y_q  <= '0;
			dx_q     <= '0;
			dy_q     <= '0;
			sxn_q    <= 1'b0;
			syn_q    <= 1'b0;
			err_q    <= '0;
			active_q <= 1'b0;
		end else if (fire) begin
			if (!is_step) begin
				cur_x_q  <= ax;
				cur_y_q  <= ay;
				tgt_x_q  <= bx;
				tgt_y_q  <= by;
				dx_q     <= new_dx;
				dy_q     <= new_dy;
				sxn_q    <= !x_fwd;
				syn_q    <= !y_fwd;
				err_q    <= new_err;
				active_q <= 1'b1;
			end else if (active_q) begin
				if (at_end) begin
					active_q <= 1'b0;
				end else begin
					cur_x_q <= nxt_x;
					cur_y_q <= nxt_y;
					err_q   <= err_sum[EW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && is_step) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_step) begin
			out_x_q    <= cur_x_q;
			out_y_q    <= cur_y_q;
			out_addr_q <= pix_addr;
			out_vis_q  <= pix_vis;
			out_last_q <= !live;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.pixel_x       = out_x_q;
	assign rsp.pixel_y       = out_y_q;
	assign rsp.pixel_address = out_addr_q;
	assign rsp.visible       = out_vis_q;
	assign rsp.last          = out_last_q;

	a_vis_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_vis_q) |-> !out_last_q)
		else $error("visible result marked last");

	a_hidden_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_vis_q) |-> (out_addr_q == '0))
		else $error("hidden result with nonzero address");

	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !is_step) |=> (active_q && !$rose(out_valid_q)))
		else $error("start did not arm line or produced a result");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_step && !active_q) |=>
			($stable(cur_x_q) && $stable(cur_y_q) && out_last_q && !active_q))
		else $error("step without line changed state");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_step && active_q && at_end) |=> (!active_q && out_last_q))
		else $error("end point step did not close the line");

endmodule

`default_nettype wire

### test/bresenham_line_stepper_unit_test.sv
module bresenham_line_stepper_unit_test;
	import blsu_pkg::*;

	localparam int COORD_BITS = COORD_BITS_DEF;
	localparam logic [REG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
	localparam logic [REG_IDX_BITS-1:0] REG_SPARE  = 3'd6;
	localparam int LONG_HOLD = 300;

	typedef struct {
		blsu_cmd_t                    cmd;
		logic signed [COORD_BITS-1:0] sx;
		logic signed [COORD_BITS-1:0] sy;
		logic signed [COORD_BITS-1:0] ex;
		logic signed [COORD_BITS-1:0] ey;
	} line_req_t;

	typedef struct {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [ADDR_BITS-1:0]         addr;
		logic                         vis;
		logic                         last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [REG_IDX_BITS-1:0] wr_index;
	logic [WR_DATA_BITS-1:0] wr_data;

	blsu_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
	blsu_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_ch ();

	bresenham_line_stepper_unit #(.COORD_BITS(COORD_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #5 clk = ~clk;

	line_req_t pending_line_reqs[$];
	pixel_t    expected_pixels[$];

	blsu_cfg_t line_cfg;
	longint    ln_x, ln_y, ln_tx, ln_ty, ln_dx, ln_dy, ln_err;
	bit        ln_x_neg, ln_y_neg, ln_active;

	int send_idle_pct;
	int recv_stall_pct;
	bit pressure_armed;
	int mismatch_count;
	int accepted_reqs, accepted_starts;
	int pixel_count, visible_count, last_count;

	task automatic trace_line_request(input blsu_cmd_t cmd, input longint ax, input longint ay,
		input longint bx, input longint by);
		pixel_t px;
		longint e2;
		if (cmd == CMD_START) begin
			ln_dx = (bx > ax) ? bx - ax : ax - bx;
			ln_dy = (by > ay) ? by - ay : ay - by;
			ln_x_neg = !(ax < bx);
			ln_y_neg = !(ay < by);
			ln_err = ln_dx - ln_dy;
			ln_x = ax;
			ln_y = ay;
			ln_tx = bx;
			ln_ty = by;
			ln_active = 1'b1;
		end else begin
			px.x = ln_x[COORD_BITS-1:0];
			px.y = ln_y[COORD_BITS-1:0];
			px.addr = '0;
			px.vis = 1'b0;
			px.last = 1'b1;
			if (ln_active && ln_x == ln_tx && ln_y == ln_ty) begin
				ln_active = 1'b0;
			end else if (ln_active) begin
				px.last = 1'b0;
				px.vis = ln_x > longint'(line_cfg.clip_left) &&
					ln_x < longint'(line_cfg.clip_right) &&
					ln_y > 0 && ln_y < longint'(line_cfg.clip_height);
				if (px.vis) begin
					px.addr = ADDR_BITS'((ln_x * longint'(line_cfg.bpp)) / BYTE_BITS +
						ln_y * longint'(line_cfg.row_stride));
				end
				e2 = 2 * ln_err;
				if (e2 > -ln_dy) begin
					ln_err = ln_err - ln_dy;
					ln_x = ln_x_neg ? ln_x - 1 : ln_x + 1;
				end
				if (e2 < ln_dx) begin
					ln_err = ln_err + ln_dx;
					ln_y = ln_y_neg ? ln_y - 1 : ln_y + 1;
				end
			end
			expected_pixels.push_back(px);
		end
	endtask

	function automatic void check_field(input string field, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		line_req_t nxt;
		if (req_ch.valid && req_ch.ready) begin
			trace_line_request(blsu_cmd_t'(req_ch.cmd), req_ch.start_x, req_ch.start_y,
				req_ch.end_x, req_ch.end_y);
			accepted_reqs++;
			if (req_ch.cmd == CMD_START)
				accepted_starts++;
		end
		if (!req_ch.valid || req_ch.ready) begin
			if (pending_line_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_line_reqs.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.cmd <= nxt.cmd;
				req_ch.start_x <= nxt.sx;
				req_ch.start_y <= nxt.sy;
				req_ch.end_x <= nxt.ex;
				req_ch.end_y <= nxt.ey;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	int hold_count = 0;

	always @(posedge clk) begin
		pixel_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d", $time, rsp_ch.pixel_x,
					rsp_ch.pixel_y);
				mismatch_count++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("pixel_x", 64'(want.x), 64'(rsp_ch.pixel_x));
				check_field("pixel_y", 64'(want.y), 64'(rsp_ch.pixel_y));
				check_field("pixel_address", 64'(want.addr), 64'(rsp_ch.pixel_address));
				check_field("visible", 64'(want.vis), 64'(rsp_ch.visible));
				check_field("last", 64'(want.last), 64'(rsp_ch.last));
				pixel_count++;
				if (want.vis)
					visible_count++;
				if (want.last)
					last_count++;
			end
		end
		if (pressure_armed && hold_count < LONG_HOLD) begin
			rsp_ch.ready <= 1'b0;
			hold_count++;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [WR_DATA_BITS-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_CLIP_LEFT:   line_cfg.clip_left = val[CLIP_BITS-1:0];
			REG_CLIP_RIGHT:  line_cfg.clip_right = val[CLIP_BITS-1:0];
			REG_CLIP_HEIGHT: line_cfg.clip_height = val[CLIP_BITS-1:0];
			REG_BPP:         line_cfg.bpp = val[BPP_BITS-1:0];
			REG_ROW_STRIDE:  line_cfg.row_stride = val[STRIDE_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic queue_start(input longint sx, input longint sy, input longint ex,
		input longint ey);
		line_req_t r;
		r.cmd = CMD_START;
		r.sx = COORD_BITS'(sx);
		r.sy = COORD_BITS'(sy);
		r.ex = COORD_BITS'(ex);
		r.ey = COORD_BITS'(ey);
		pending_line_reqs.push_back(r);
	endtask

	task automatic queue_steps(input int n);
		line_req_t r;
		repeat (n) begin
			r.cmd = CMD_STEP;
			r.sx = COORD_BITS'($urandom);
			r.sy = COORD_BITS'($urandom);
			r.ex = COORD_BITS'($urandom);
			r.ey = COORD_BITS'($urandom);
			pending_line_reqs.push_back(r);
		end
	endtask

	task automatic queue_random_lines(input int budget);
		int added, kind, nsteps;
		longint sx, sy, ex, ey, ax, ay;
		added = 0;
		while (added < budget) begin
			kind = int'($urandom_range(99));
			if (kind < 70) begin
				sx = longint'($urandom_range(line_cfg.clip_right + 200)) - 100;
				sy = longint'($urandom_range(line_cfg.clip_height + 200)) - 100;
				ex = sx + $urandom_range(48) - 24;
				ey = sy + $urandom_range(48) - 24;
				ax = (ex > sx) ? ex - sx : sx - ex;
				ay = (ey > sy) ? ey - sy : sy - ey;
				nsteps = int'(((ax > ay) ? ax : ay) + 1 + $urandom_range(1));
				// cut the line short now and then so the next start lands mid-line
				if ($urandom_range(99) < 15)
					nsteps = int'($urandom_range(nsteps));
				queue_start(sx, sy, ex, ey);
				queue_steps(nsteps);
				added += 1 + nsteps;
			end else if (kind < 85) begin
				nsteps = int'($urandom_range(4, 1));
				queue_start($urandom, $urandom, $urandom, $urandom);
				queue_steps(nsteps);
				added += 1 + nsteps;
			end else if (kind < 93) begin
				nsteps = int'($urandom_range(3, 1));
				queue_steps(nsteps);
				added += nsteps;
			end else begin
				queue_start($urandom, $urandom, $urandom, $urandom);
				added += 1;
			end
		end
	endtask

	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (pending_line_reqs.size() != 0 || req_ch.valid ||
			expected_pixels.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_STEP;
		req_ch.start_x = '0;
		req_ch.start_y = '0;
		req_ch.end_x = '0;
		req_ch.end_y = '0;
		rsp_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		pressure_armed = 1'b0;
		mismatch_count = 0;
		line_cfg.clip_left = CLIP_LEFT_RST;
		line_cfg.clip_right = CLIP_RIGHT_RST;
		line_cfg.clip_height = CLIP_HEIGHT_RST;
		line_cfg.bpp = BPP_RST;
		line_cfg.row_stride = ROW_STRIDE_RST;
		ln_x = 0;
		ln_y = 0;
		ln_tx = 0;
		ln_ty = 0;
		ln_dx = 0;
		ln_dy = 0;
		ln_err = 0;
		ln_x_neg = 1'b0;
		ln_y_neg = 1'b0;
		ln_active = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no line loaded yet
		queue_steps(1);
		queue_start(10, 10, 13, 11);
		queue_steps(5);
		queue_start(5, 5, 5, 5);
		queue_steps(2);
		queue_start(-32768, 32767, 32767, -32768);
		queue_steps(2);
		// equal x: x never moves; then restart mid-line across the window corner
		queue_start(100, 100, 100, 96);
		queue_steps(2);
		queue_start(1919, 1079, 1921, 1081);
		queue_steps(3);
		queue_start(0, 1, 2, 1);
		queue_steps(2);
		queue_random_lines(100);
		drain();

		write_reg(REG_CLIP_LEFT, 16'hF000);
		write_reg(REG_CLIP_RIGHT, 16'hFFFF);
		write_reg(REG_CLIP_HEIGHT, 16'hFFFF);
		write_reg(REG_BPP, 16'hFFC0);
		write_reg(REG_ROW_STRIDE, 16'hFFFF);
		write_reg(REG_UNUSED, WR_DATA_BITS'($urandom));
		send_idle_pct = 51;
		queue_start(4094, 4094, 4096, 4096);
		queue_steps(3);
		queue_start(32767, 32767, 32765, 32765);
		queue_steps(3);
		queue_random_lines(120);
		drain();

		write_reg(REG_CLIP_LEFT, 16'h0FFF);
		write_reg(REG_CLIP_RIGHT, 16'hF001);
		write_reg(REG_CLIP_HEIGHT, 16'h0001);
		write_reg(REG_BPP, 16'h0008);
		write_reg(REG_ROW_STRIDE, 16'h0001);
		send_idle_pct = 0;
		recv_stall_pct = 51;
		queue_random_lines(120);
		drain();

		write_reg(REG_CLIP_LEFT, WR_DATA_BITS'($urandom_range(200)));
		write_reg(REG_CLIP_RIGHT, WR_DATA_BITS'($urandom_range(4095, 500)));
		write_reg(REG_CLIP_HEIGHT, WR_DATA_BITS'($urandom_range(4095, 300)));
		write_reg(REG_BPP, WR_DATA_BITS'($urandom_range(64, 8)));
		write_reg(REG_ROW_STRIDE, WR_DATA_BITS'($urandom_range(65535, 1)));
		write_reg(REG_SPARE, WR_DATA_BITS'($urandom));
		send_idle_pct = 8;
		recv_stall_pct = 8;
		queue_random_lines(120);
		drain();

		write_reg(REG_CLIP_LEFT, WR_DATA_BITS'($urandom_range(50)));
		write_reg(REG_CLIP_RIGHT, WR_DATA_BITS'($urandom_range(2500, 1000)));
		write_reg(REG_CLIP_HEIGHT, WR_DATA_BITS'($urandom_range(1500, 600)));
		write_reg(REG_BPP, WR_DATA_BITS'($urandom_range(64, 8)));
		write_reg(REG_ROW_STRIDE, WR_DATA_BITS'($urandom_range(16000, 1)));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		pressure_armed = 1'b1;
		queue_random_lines(120);
		drain();

		$display("Stepped %0d requests (%0d line starts) through five clip/format settings,",
			accepted_reqs, accepted_starts);
		$display("checking %0d pixels: %0d inside the window, %0d at end of line or idle.",
			pixel_count, visible_count, last_count);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
